[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands. Clock clk, synchronous active-low reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[src/vmba_pkg.sv]
// ----------------------------------------------------------------------------
// vmba_pkg
// Shared types, codes and size decode for the video memory bump allocator.
// ----------------------------------------------------------------------------
package vmba_pkg;

  localparam int PointerBitsDef = 32;
  localparam int DimBits        = 12;
  localparam int PxBits         = 2 * DimBits;
  localparam int BaseBits       = 26;
  localparam int FmtBits        = 4;
  localparam int PageShift      = 11;
  localparam int BlockShift     = 6;
  localparam int PageWords      = 1 << PageShift;
  localparam int BlockWords     = 1 << BlockShift;

  typedef enum logic [1:0] {
    CMD_ALLOC_FRAME = 2'd0,
    CMD_ALLOC_TEX   = 2'd1,
    CMD_FREE_TEX    = 2'd2,
    CMD_FREE_ALL    = 2'd3
  } cmd_t;

  localparam logic [FmtBits-1:0] FMT_C32  = 4'd0;
  localparam logic [FmtBits-1:0] FMT_C24  = 4'd1;
  localparam logic [FmtBits-1:0] FMT_C16  = 4'd2;
  localparam logic [FmtBits-1:0] FMT_C16S = 4'd3;
  localparam logic [FmtBits-1:0] FMT_T8   = 4'd4;
  localparam logic [FmtBits-1:0] FMT_T4   = 4'd5;
  localparam logic [FmtBits-1:0] FMT_T8H  = 4'd6;
  localparam logic [FmtBits-1:0] FMT_T4HH = 4'd7;
  localparam logic [FmtBits-1:0] FMT_T4HL = 4'd8;
  localparam logic [FmtBits-1:0] FMT_Z32  = 4'd9;
  localparam logic [FmtBits-1:0] FMT_Z24  = 4'd10;
  localparam logic [FmtBits-1:0] FMT_Z16  = 4'd11;

  typedef struct packed {
    logic              ok;
    logic [PxBits-1:0] words;
  } size_t;

  function automatic size_t image_words(input logic [PxBits-1:0] px,
                                        input logic [FmtBits-1:0] fmt,
                                        input logic frame);
    size_t s;
    s.ok    = 1'b1;
    s.words = px;
    case (fmt) inside
      FMT_C32, FMT_C24, FMT_T8H, FMT_T4HH, FMT_T4HL: s.words = px;
      FMT_Z32, FMT_Z24: begin
        s.words = px;
        s.ok    = frame;
      end
      FMT_C16, FMT_C16S: s.words = px >> 1;
      FMT_Z16: begin
        s.words = px >> 1;
        s.ok    = frame;
      end
      FMT_T8: s.words = px >> 2;
      FMT_T4: s.words = px >> 3;
      default: s.ok = 1'b0;
    endcase
    return s;
  endfunction

endpackage

[src/video_memory_bump_allocator_unit.sv]
// ----------------------------------------------------------------------------
// video_memory_bump_allocator_unit
// Linear video-memory allocator: frame pages, texture blocks, rewinds.
// ----------------------------------------------------------------------------
//  channel | ports                                          | dir
//  --------+------------------------------------------------+----
//  in      | in_valid in_stall in_cmd in_width in_height    | in
//          | in_pixel_format                                |
//  out     | out_valid out_stall out_base_index out_status  | out
//
//  One word per cycle unless a held result stalls the input; the result shows in the cycle after acceptance.
//  Pointers update at the acceptance edge, so requests chain back to back.
//  in_stall is high only while a held result is stalled at the output.
//  Reset clears both pointers and the output valid.
// ----------------------------------------------------------------------------
module video_memory_bump_allocator_unit
  import vmba_pkg::*;
#(
  parameter int POINTER_BITS = PointerBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_cmd,
  input  logic [DimBits-1:0]  in_width,
  input  logic [DimBits-1:0]  in_height,
  input  logic [FmtBits-1:0]  in_pixel_format,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BaseBits-1:0] out_base_index,
  output logic                out_status
);

  localparam int SumBits = (POINTER_BITS > PxBits) ? POINTER_BITS : PxBits;

  logic [POINTER_BITS-1:0] free_r, free_nxt;
  logic [POINTER_BITS-1:0] tex_r, tex_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [BaseBits-1:0]     base_r, base_nxt;
  logic                    status_r, status_nxt;

  logic                    accept;
  logic                    frame;
  logic [PxBits-1:0]       px;
  size_t                   sz;
  logic [POINTER_BITS-1:0] page_al, blk_al, al;
  logic [SumBits-1:0]      sum;
  cmd_t                    cmd;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign cmd      = cmd_t'(in_cmd);
  assign frame    = (cmd == CMD_ALLOC_FRAME);

  assign px      = PxBits'(in_width) * PxBits'(in_height);
  assign sz      = image_words(px, in_pixel_format, frame);
  assign page_al = (free_r + POINTER_BITS'(PageWords - 1)) & ~POINTER_BITS'(PageWords - 1);
  assign blk_al  = (free_r + POINTER_BITS'(BlockWords - 1)) & ~POINTER_BITS'(BlockWords - 1);
  assign al      = frame ? page_al : blk_al;
  assign sum     = SumBits'(al) + SumBits'(sz.words);

  always_comb begin
    free_nxt   = free_r;
    tex_nxt    = tex_r;
    base_nxt   = '0;
    status_nxt = 1'b0;
    case (cmd)
      CMD_ALLOC_FRAME, CMD_ALLOC_TEX: begin
        if (!sz.ok) begin
          status_nxt = 1'b1;
        end else begin
          base_nxt = frame ? BaseBits'(al >> PageShift) : BaseBits'(al >> BlockShift);
          free_nxt = sum[POINTER_BITS-1:0];
          if (frame) begin
            tex_nxt = sum[POINTER_BITS-1:0];
          end
        end
      end
      CMD_FREE_TEX: free_nxt = tex_r;
      CMD_FREE_ALL: begin
        free_nxt = '0;
        tex_nxt  = '0;
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = accept | in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= '0;
      tex_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        free_r <= free_nxt;
        tex_r  <= tex_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base_r   <= base_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_base_index = base_r;
  assign out_status     = status_r;

endmodule

[src/vmba_checker.sv]
// ----------------------------------------------------------------------------
// vmba_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vmba_checker
  import vmba_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic [1:0]          in_cmd,
  input logic [FmtBits-1:0]  in_pixel_format,
  input logic                out_valid,
  input logic                out_stall,
  input logic [BaseBits-1:0] out_base_index,
  input logic                out_status
);

  logic acc;
  logic free_cmd;
  logic bad_fmt;

  assign acc      = in_valid & ~in_stall;
  assign free_cmd = (in_cmd == CMD_FREE_TEX) || (in_cmd == CMD_FREE_ALL);
  assign bad_fmt  = (in_cmd == CMD_ALLOC_FRAME) && (in_pixel_format > FMT_Z16);

  `ASSERT_NEXT(a_result_follows, acc, out_valid)
  `ASSERT_NEXT(a_hold_stalled, out_valid && out_stall, out_valid && $stable(out_base_index) && $stable(out_status))
  `ASSERT_NOW(a_error_zero_base, out_valid && out_status, out_base_index == '0)
  `ASSERT_NEXT(a_free_clean, acc && free_cmd, out_status == 1'b0 && out_base_index == '0)
  `ASSERT_NEXT(a_bad_format, acc && bad_fmt, out_status == 1'b1)

endmodule

bind video_memory_bump_allocator_unit vmba_checker u_vmba_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_cmd          (in_cmd),
  .in_pixel_format (in_pixel_format),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_base_index  (out_base_index),
  .out_status      (out_status)
);
